// ----- rtl/ups_telemetry_decoder_assert.svh -----
// ----------------------------------------------------------------------------
// ups telemetry decoder assertion macros
// concurrent checks, compiled out for synthesis
// ----------------------------------------------------------------------------
`ifndef UPS_TELEMETRY_DECODER_ASSERT_SVH
`define UPS_TELEMETRY_DECODER_ASSERT_SVH
`ifndef SYNTHESIS
// property must hold at every clock edge outside reset
`define UTD_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// condition must never be seen outside reset
`define UTD_NEVER(lbl, clk, rst_n, cond, msg) \
    `UTD_ASSERT(lbl, clk, rst_n, !(cond), msg)
`else
`define UTD_ASSERT(lbl, clk, rst_n, prop, msg)
`define UTD_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

// ----- rtl/utd_pkg.sv -----
// ----------------------------------------------------------------------------
// utd_pkg
// shared types, constants and constant tables of the telemetry decoder
// ----------------------------------------------------------------------------
package utd_pkg;

    localparam int VOLT_MAX = 2000;
    localparam int PROD_W   = 96;
    localparam int DVD_W    = 64;
    localparam int DEN_W    = 40;
    localparam int ACC_W    = 64;

    localparam logic [7:0] EMPTY_RESET = 8'd168;
    localparam logic [7:0] FULL_RESET  = 8'd215;
    localparam logic [26:0] FREQ_SCALE = 27'd100000000;

    localparam logic [7:0] REG_NORMAL = 8'd48;
    localparam logic [7:0] REG_BOOST  = 8'd49;
    localparam logic [7:0] REG_TRIM   = 8'd50;
    localparam logic [7:0] LINE_ONLINE  = 8'd48;
    localparam logic [7:0] LINE_ON_BATT = 8'd49;
    localparam logic [7:0] LINE_LOW_BATT = 8'd50;

    localparam longint NODES9 [7]  = '{144, 154, 184, 195, 215, 228, 249};
    localparam longint VALS9 [7]   = '{951, 983, 1126, 1165, 1260, 1310, 1403};
    localparam longint NODES10 [7] = '{75, 83, 87, 98, 103, 118, 145};
    localparam longint VALS10 [7]  = '{960, 1020, 1050, 1130, 1160, 1240, 1400};

    typedef enum logic [0:0] {
        CFG_EMPTY = 1'b0,
        CFG_FULL  = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic        ten_byte_format;
        logic [7:0]  volt_high;
        logic [7:0]  volt_low;
        logic [7:0]  batt_raw;
        logic [15:0] period_count;
        logic [7:0]  regulation_code;
        logic [7:0]  line_code;
    } t_in_item;

    typedef struct packed {
        logic [10:0]        volt_tenths;
        logic [10:0]        max_volt_tenths;
        logic [10:0]        min_volt_tenths;
        logic signed [15:0] battery_tenths_pct;
        logic [26:0]        freq_hundredths;
        logic               period_zero;
        logic               boost;
        logic               trim;
        logic               on_line;
        logic               on_battery;
        logic               low_battery;
    } t_out_item;

    typedef enum logic [3:0] {
        ST_IDLE, ST_SQRT, ST_BRANCH, ST_TERM, ST_MLOAD, ST_MUL, ST_TDIV_LD, ST_TDIV,
        ST_ACC, ST_VOLT, ST_BDIV_LD, ST_BDIV, ST_FDIV_LD, ST_FDIV, ST_OUT
    } t_state;

    typedef enum logic [1:0] {
        DIV_TERM,
        DIV_BATT,
        DIV_FREQ
    } t_div_sel;

    typedef struct packed {
        logic     load_in;
        logic     sq_step;
        logic     term_start;
        logic     mul_start;
        logic     mul_step;
        logic     div_load;
        t_div_sel div_sel;
        logic     div_step;
        logic     acc_term;
        logic     volt_fin;
        logic     batt_fin;
        logic     out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic sq_last;
        logic ten_direct;
        logic mul_done;
        logic j_end;
        logic div_last;
        logic term_last;
        logic out_free;
    } t_dp_sts;

    typedef logic [10:0] t_curve9_tbl [256];
    typedef logic [DEN_W-1:0] t_den_tbl [7];
    typedef longint t_den9_tbl [7];

    // signed node products of the nine-byte curve
    function automatic t_den9_tbl build_den9();
        t_den9_tbl tbl;
        longint d;
        for (int i = 0; i < 7; i++) begin
            d = 1;
            for (int j = 0; j < 7; j++) begin
                if (j != i) d = d * (NODES9[i] - NODES9[j]);
            end
            tbl[i] = d;
        end
        return tbl;
    endfunction

    localparam t_den9_tbl DEN9 = build_den9();

    // nine-byte curve, worked out at elaboration
    function automatic t_curve9_tbl build_curve9();
        t_curve9_tbl tbl;
        longint acc;
        longint n;
        longint r;
        for (int v = 0; v < 256; v++) begin
            acc = 0;
            for (int i = 0; i < 7; i++) begin
                n = 1;
                for (int j = 0; j < 7; j++) begin
                    if (j != i) begin
                        n = n * (longint'(v) - NODES9[j]);
                    end
                end
                acc = acc + VALS9[i] * n * 256 / DEN9[i];
            end
            if (longint'(v) < NODES9[0] || acc <= 0) begin
                tbl[v] = '0;
            end else begin
                r = (acc + 128) >>> 8;
                tbl[v] = (r > VOLT_MAX) ? 11'(VOLT_MAX) : 11'(r);
            end
        end
        return tbl;
    endfunction

    function automatic t_den_tbl build_den10_abs();
        t_den_tbl tbl;
        longint d;
        for (int i = 0; i < 7; i++) begin
            d = 1;
            for (int j = 0; j < 7; j++) begin
                if (j != i) d = d * (NODES10[i] - NODES10[j]);
            end
            tbl[i] = DEN_W'((d < 0) ? -d : d);
        end
        return tbl;
    endfunction

    function automatic logic [6:0] build_den10_neg();
        logic [6:0] m;
        longint d;
        for (int i = 0; i < 7; i++) begin
            d = 1;
            for (int j = 0; j < 7; j++) begin
                if (j != i) d = d * (NODES10[i] - NODES10[j]);
            end
            m[i] = (d < 0);
        end
        return m;
    endfunction

    function automatic logic [7:0] node10_at(logic [2:0] k);
        logic [7:0] r;
        case (k)
            3'd0:    r = 8'(NODES10[0]);
            3'd1:    r = 8'(NODES10[1]);
            3'd2:    r = 8'(NODES10[2]);
            3'd3:    r = 8'(NODES10[3]);
            3'd4:    r = 8'(NODES10[4]);
            3'd5:    r = 8'(NODES10[5]);
            3'd6:    r = 8'(NODES10[6]);
            default: r = '0;
        endcase
        return r;
    endfunction

    function automatic logic [10:0] val10_at(logic [2:0] k);
        logic [10:0] r;
        case (k)
            3'd0:    r = 11'(VALS10[0]);
            3'd1:    r = 11'(VALS10[1]);
            3'd2:    r = 11'(VALS10[2]);
            3'd3:    r = 11'(VALS10[3]);
            3'd4:    r = 11'(VALS10[4]);
            3'd5:    r = 11'(VALS10[5]);
            3'd6:    r = 11'(VALS10[6]);
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

// ----- rtl/utd_in_if.sv -----
// ----------------------------------------------------------------------------
// utd_in_if
// packet channel into the decoder
// ----------------------------------------------------------------------------
interface utd_in_if;
    logic              valid;
    logic              ready;
    utd_pkg::t_in_item payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// ----- rtl/utd_out_if.sv -----
// ----------------------------------------------------------------------------
// utd_out_if
// result channel out of the decoder
// ----------------------------------------------------------------------------
interface utd_out_if;
    logic               valid;
    logic               ready;
    utd_pkg::t_out_item payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// ----- rtl/utd_dp.sv -----
// ----------------------------------------------------------------------------
// utd_dp
// datapath: square root, lagrange terms, shared divider, result register
// ----------------------------------------------------------------------------
`include "ups_telemetry_decoder_assert.svh"

module utd_dp (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  utd_pkg::t_dp_cmd   i_cmd,
    output utd_pkg::t_dp_sts   o_sts,
    input  utd_pkg::t_in_item  i_item,
    input  logic               i_cfg_we,
    input  logic [0:0]         i_cfg_idx,
    input  logic [7:0]         i_cfg_data,
    input  logic               i_out_ready,
    output logic               o_out_valid,
    output utd_pkg::t_out_item o_out_item
);

    localparam utd_pkg::t_curve9_tbl CURVE9 = utd_pkg::build_curve9();
    localparam utd_pkg::t_den_tbl DEN10_ABS = utd_pkg::build_den10_abs();
    localparam logic [6:0] DEN10_NEG = utd_pkg::build_den10_neg();
    localparam logic [15:0] S_LOW  = 16'(utd_pkg::NODES10[0] * 256);
    localparam logic [15:0] S_HIGH = 16'(utd_pkg::NODES10[6] * 256);
    localparam int PW = utd_pkg::PROD_W;
    localparam int QW = utd_pkg::DVD_W;
    localparam int DW = utd_pkg::DEN_W;

    logic [7:0]               r_empty;
    logic [7:0]               r_full;
    utd_pkg::t_in_item        r_item;
    logic [31:0]              r_sq_x;
    logic [32:0]              r_sq_res;
    logic [30:0]              r_sq_bit;
    logic [3:0]               r_sq_cnt;
    logic [2:0]               r_i;
    logic [2:0]               r_j;
    logic [PW-1:0]            r_prod;
    logic [PW-1:0]            r_mcand;
    logic [14:0]              r_mplier;
    logic                     r_neg;
    logic signed [utd_pkg::ACC_W-1:0] r_acc;
    logic [DW:0]              r_div_rem;
    logic [QW-1:0]            r_div_quo;
    logic [DW-1:0]            r_div_den;
    logic [5:0]               r_div_cnt;
    logic [10:0]              r_volt;
    logic                     r_batt_neg;
    logic                     r_batt_zero;
    logic signed [15:0]       r_batt;
    logic [10:0]              r_max;
    logic [10:0]              r_min;
    logic                     r_out_valid;
    utd_pkg::t_out_item       r_out;

    logic [15:0] s;
    logic [33:0] sq_sum;
    logic        sq_ge;
    logic        s_low;
    logic        s_high;
    logic        s_node;
    logic [10:0] s_node_val;
    logic [17:0] diff;
    logic        diff_neg;
    logic [17:0] diff_abs;
    logic [DW:0] div_sh;
    logic        div_ge;
    logic [64:0] round_sum;
    logic [48:0] round_q;
    logic [10:0] volt10;
    logic [7:0]  bmag;
    logic [7:0]  dmag;
    logic [17:0] an;
    logic [18:0] batt_dvd;
    logic [10:0] n_max;
    logic [10:0] n_min;

    assign s      = r_sq_res[15:0];
    assign sq_sum = {1'b0, r_sq_res} + {3'b0, r_sq_bit};
    assign sq_ge  = {2'b0, r_sq_x} >= sq_sum;
    assign s_low  = s < S_LOW;
    assign s_high = s > S_HIGH;

    // integer part of the root on a node
    always_comb begin
        s_node     = 1'b0;
        s_node_val = '0;
        for (int k = 0; k < 7; k++) begin
            if (s[15:8] == utd_pkg::node10_at(3'(k))) begin
                s_node     = 1'b1;
                s_node_val = utd_pkg::val10_at(3'(k));
            end
        end
    end

    assign diff     = {2'b0, s} - {2'b0, utd_pkg::node10_at(r_j), 8'b0};
    assign diff_neg = diff[17];
    assign diff_abs = diff_neg ? (18'd0 - diff) : diff;

    assign div_sh = {r_div_rem[DW-1:0], r_div_quo[QW-1]};
    assign div_ge = div_sh >= {1'b0, r_div_den};

    // q16 tenths, rounded half up
    assign round_sum = {1'b0, r_acc} + 65'd32768;
    assign round_q   = round_sum[64:16];
    always_comb begin
        if (r_acc <= 0) begin
            volt10 = '0;
        end else if (round_q > 49'(utd_pkg::VOLT_MAX)) begin
            volt10 = 11'(utd_pkg::VOLT_MAX);
        end else begin
            volt10 = round_q[10:0];
        end
    end

    assign bmag     = (r_item.batt_raw >= r_empty) ? (r_item.batt_raw - r_empty)
                                                   : (r_empty - r_item.batt_raw);
    assign dmag     = (r_full >= r_empty) ? (r_full - r_empty) : (r_empty - r_full);
    assign an       = {10'b0, bmag} * 18'd1000;
    assign batt_dvd = {an, 1'b0} + {11'b0, dmag};

    assign n_max = (r_volt >= r_max) ? r_volt : r_max;
    assign n_min = (r_volt <= r_min) ? r_volt : r_min;

    // configuration and running extremes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_empty     <= utd_pkg::EMPTY_RESET;
            r_full      <= utd_pkg::FULL_RESET;
            r_max       <= '0;
            r_min       <= '1;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == utd_pkg::CFG_EMPTY) r_empty <= i_cfg_data;
                else r_full <= i_cfg_data;
            end
            if (i_cmd.out_load) begin
                r_max       <= n_max;
                r_min       <= n_min;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_item   <= i_item;
            r_sq_x   <= {i_item.volt_high, i_item.volt_low, 16'b0};
            r_sq_res <= '0;
            r_sq_bit <= 31'h4000_0000;
            r_sq_cnt <= 4'd15;
            r_i      <= '0;
            r_acc    <= '0;
        end
        if (i_cmd.sq_step) begin
            if (sq_ge) begin
                r_sq_x   <= 32'({2'b0, r_sq_x} - sq_sum);
                r_sq_res <= (r_sq_res >> 1) + {2'b0, r_sq_bit};
            end else begin
                r_sq_res <= r_sq_res >> 1;
            end
            r_sq_bit <= r_sq_bit >> 2;
            r_sq_cnt <= r_sq_cnt - 4'd1;
        end
        if (i_cmd.term_start) begin
            r_prod <= PW'(utd_pkg::val10_at(r_i));
            r_neg  <= DEN10_NEG[r_i];
            r_j    <= '0;
        end
        if (i_cmd.mul_start) begin
            r_mcand <= r_prod;
            r_prod  <= '0;
            r_j     <= r_j + 3'd1;
            if (r_j == r_i) begin
                r_mplier <= 15'd1;
            end else begin
                r_mplier <= diff_abs[14:0];
                r_neg    <= r_neg ^ diff_neg;
            end
        end
        if (i_cmd.mul_step) begin
            if (r_mplier[0]) r_prod <= r_prod + r_mcand;
            r_mcand  <= r_mcand << 1;
            r_mplier <= r_mplier >> 1;
        end
        if (i_cmd.div_load) begin
            r_div_rem <= '0;
            r_div_cnt <= 6'd63;
            case (i_cmd.div_sel)
                utd_pkg::DIV_TERM: begin
                    r_div_quo <= r_prod[PW-1:PW-QW];
                    r_div_den <= DEN10_ABS[r_i];
                end
                utd_pkg::DIV_BATT: begin
                    r_div_quo   <= QW'(batt_dvd);
                    r_div_den   <= DW'({dmag, 1'b0});
                    r_batt_neg  <= (r_item.batt_raw < r_empty) ^ (r_full < r_empty);
                    r_batt_zero <= (r_full == r_empty);
                end
                default: begin
                    r_div_quo <= QW'(utd_pkg::FREQ_SCALE)
                                 + QW'(r_item.period_count[15:1]);
                    r_div_den <= DW'(r_item.period_count);
                end
            endcase
        end
        if (i_cmd.div_step) begin
            r_div_rem <= div_ge ? (div_sh - {1'b0, r_div_den}) : div_sh;
            r_div_quo <= {r_div_quo[QW-2:0], div_ge};
            r_div_cnt <= r_div_cnt - 6'd1;
        end
        if (i_cmd.acc_term) begin
            r_acc <= r_neg ? (r_acc - $signed(r_div_quo)) : (r_acc + $signed(r_div_quo));
            r_i   <= r_i + 3'd1;
        end
        if (i_cmd.volt_fin) begin
            if (!r_item.ten_byte_format) r_volt <= CURVE9[r_item.volt_high];
            else if (s_low)              r_volt <= '0;
            else if (s_high)             r_volt <= utd_pkg::val10_at(3'd6);
            else if (s_node)             r_volt <= s_node_val;
            else                         r_volt <= volt10;
        end
        if (i_cmd.batt_fin) begin
            if (r_batt_zero) begin
                r_batt <= '0;
            end else if (r_batt_neg) begin
                r_batt <= (r_div_quo > 64'd32768) ? 16'sh8000 : -$signed(r_div_quo[15:0]);
            end else begin
                r_batt <= (r_div_quo > 64'd32767) ? 16'sh7fff : $signed(r_div_quo[15:0]);
            end
        end
        if (i_cmd.out_load) begin
            r_out.volt_tenths        <= r_volt;
            r_out.max_volt_tenths    <= n_max;
            r_out.min_volt_tenths    <= n_min;
            r_out.battery_tenths_pct <= r_batt;
            r_out.period_zero        <= (r_item.period_count == '0);
            r_out.freq_hundredths    <= (r_item.period_count == '0) ? '0 : r_div_quo[26:0];
            r_out.boost              <= (r_item.regulation_code == utd_pkg::REG_BOOST);
            r_out.trim               <= (r_item.regulation_code == utd_pkg::REG_TRIM);
            r_out.on_line            <= (r_item.line_code == utd_pkg::LINE_ONLINE);
            r_out.on_battery         <= (r_item.line_code == utd_pkg::LINE_ON_BATT)
                                        || (r_item.line_code == utd_pkg::LINE_LOW_BATT);
            r_out.low_battery        <= (r_item.line_code == utd_pkg::LINE_LOW_BATT);
        end
    end

    assign o_sts.sq_last    = (r_sq_cnt == '0);
    assign o_sts.ten_direct = !r_item.ten_byte_format || s_low || s_high || s_node;
    assign o_sts.mul_done   = (r_mplier == '0);
    assign o_sts.j_end      = (r_j == 3'd7);
    assign o_sts.div_last   = (r_div_cnt == '0);
    assign o_sts.term_last  = (r_i == 3'd6);
    assign o_sts.out_free   = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    `UTD_ASSERT(a_volt_range, i_clk, i_rst_n, r_out_valid |-> (r_out.volt_tenths <= 11'd2000), "voltage beyond saturation")
    `UTD_ASSERT(a_max_min, i_clk, i_rst_n, r_out_valid |-> (r_out.max_volt_tenths >= r_out.min_volt_tenths), "running maximum below minimum")
    `UTD_ASSERT(a_freq_zero, i_clk, i_rst_n, (r_out_valid && r_out.period_zero) |-> (r_out.freq_hundredths == '0), "frequency set on zero period")

endmodule

// ----- rtl/utd_ctrl.sv -----
// ----------------------------------------------------------------------------
// utd_ctrl
// sequencer for one packet: root, curve terms, divides, result load
// ----------------------------------------------------------------------------
`include "ups_telemetry_decoder_assert.svh"

module utd_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  utd_pkg::t_dp_sts i_sts,
    output utd_pkg::t_dp_cmd o_cmd
);

    utd_pkg::t_state r_state;
    utd_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= utd_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            utd_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = utd_pkg::ST_SQRT;
                end
            end
            utd_pkg::ST_SQRT: begin
                o_cmd.sq_step = 1'b1;
                if (i_sts.sq_last) n_state = utd_pkg::ST_BRANCH;
            end
            utd_pkg::ST_BRANCH: begin
                n_state = i_sts.ten_direct ? utd_pkg::ST_VOLT : utd_pkg::ST_TERM;
            end
            utd_pkg::ST_TERM: begin
                o_cmd.term_start = 1'b1;
                n_state          = utd_pkg::ST_MLOAD;
            end
            utd_pkg::ST_MLOAD: begin
                o_cmd.mul_start = 1'b1;
                n_state         = utd_pkg::ST_MUL;
            end
            utd_pkg::ST_MUL: begin
                if (!i_sts.mul_done) begin
                    o_cmd.mul_step = 1'b1;
                end else if (i_sts.j_end) begin
                    n_state = utd_pkg::ST_TDIV_LD;
                end else begin
                    n_state = utd_pkg::ST_MLOAD;
                end
            end
            utd_pkg::ST_TDIV_LD: begin
                o_cmd.div_load = 1'b1;
                o_cmd.div_sel  = utd_pkg::DIV_TERM;
                n_state        = utd_pkg::ST_TDIV;
            end
            utd_pkg::ST_TDIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) n_state = utd_pkg::ST_ACC;
            end
            utd_pkg::ST_ACC: begin
                o_cmd.acc_term = 1'b1;
                n_state = i_sts.term_last ? utd_pkg::ST_VOLT : utd_pkg::ST_TERM;
            end
            utd_pkg::ST_VOLT: begin
                o_cmd.volt_fin = 1'b1;
                n_state        = utd_pkg::ST_BDIV_LD;
            end
            utd_pkg::ST_BDIV_LD: begin
                o_cmd.div_load = 1'b1;
                o_cmd.div_sel  = utd_pkg::DIV_BATT;
                n_state        = utd_pkg::ST_BDIV;
            end
            utd_pkg::ST_BDIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) n_state = utd_pkg::ST_FDIV_LD;
            end
            utd_pkg::ST_FDIV_LD: begin
                o_cmd.batt_fin = 1'b1;
                o_cmd.div_load = 1'b1;
                o_cmd.div_sel  = utd_pkg::DIV_FREQ;
                n_state        = utd_pkg::ST_FDIV;
            end
            utd_pkg::ST_FDIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) n_state = utd_pkg::ST_OUT;
            end
            utd_pkg::ST_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = utd_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = utd_pkg::ST_IDLE;
            end
        endcase
    end

    `UTD_ASSERT(a_out_free, i_clk, i_rst_n, o_cmd.out_load |-> i_sts.out_free, "result loaded over an untaken beat")
    `UTD_NEVER(a_mul_over, i_clk, i_rst_n, o_cmd.mul_step && i_sts.mul_done, "multiply stepped past its last bit")
    `UTD_ASSERT(a_term_need, i_clk, i_rst_n, o_cmd.term_start |-> !i_sts.ten_direct, "curve terms run for a direct voltage")

endmodule

// ----- rtl/ups_telemetry_decoder.sv -----
// ----------------------------------------------------------------------------
// ups_telemetry_decoder
// decodes one ups telemetry packet into voltage, battery, frequency and flags
// ----------------------------------------------------------------------------
// nine-byte form: the 16-step root and the two 64-step divides (battery,
//   frequency) through the one shared divider
// ten-byte form off the curve nodes adds seven terms, each a bit-serial
//   multiply plus a 64-step divide
// throughput: one packet at a time; a new beat is taken while the last result
//   waits
// reset: synchronous active low; thresholds to 168/215, maximum 0, minimum 2047
// ----------------------------------------------------------------------------
module ups_telemetry_decoder (
    input  logic       i_clk,
    input  logic       i_rst_n,
    utd_in_if.sink     i_in,
    utd_out_if.source  o_res,
    input  logic       i_cfg_we,
    input  logic [0:0] i_cfg_idx,
    input  logic [7:0] i_cfg_data
);

    // command and status between sequencer and datapath
    utd_pkg::t_dp_cmd   w_cmd;
    utd_pkg::t_dp_sts   w_sts;
    logic               w_in_ready;
    logic               w_out_valid;
    utd_pkg::t_out_item w_out_item;

    // sequencer: accepts a beat only when idle, loads the result register once
    // the previous result has been taken
    utd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (w_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    // datapath: root, lagrange terms, divider, extremes and result register
    utd_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_item      (i_in.payload),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_out_ready (o_res.ready),
        .o_out_valid (w_out_valid),
        .o_out_item  (w_out_item)
    );

    assign i_in.ready    = w_in_ready;
    assign o_res.valid   = w_out_valid;
    assign o_res.payload = w_out_item;

endmodule

// ----- tb/ups_telemetry_decoder_test.sv -----
// ----------------------------------------------------------------------------
// ups_telemetry_decoder_test
// drives telemetry packets through the decoder under several threshold
// settings and idle patterns, predicts every result and checks it field by field
// ----------------------------------------------------------------------------
module ups_telemetry_decoder_test;

    localparam longint CYCLE_LIMIT = 20000000;
    localparam int     DRAIN_WAIT  = 2000;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [0:0] i_cfg_idx;
    logic [7:0] i_cfg_data;

    utd_in_if  pkt_ch ();
    utd_out_if res_ch ();

    ups_telemetry_decoder dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (pkt_ch.sink),
        .o_res      (res_ch.source),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // packets waiting to be driven, decoded values waiting to come out
    utd_pkg::t_in_item  pending_pkts [$];
    utd_pkg::t_out_item decoded_due [$];

    // predictor copy of thresholds and running extremes
    logic [7:0]  empty_raw;
    logic [7:0]  full_raw;
    logic [10:0] peak_volt;
    logic [10:0] floor_volt;

    longint cyc;
    int     errors;
    int     beats_in;
    int     beats_out;
    int     send_idle_pct;
    int     recv_stall_pct;
    longint hold_from;
    longint hold_len;
    logic   pkt_taken;

    // clock
    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    // cycle count and overall timeout
    always @(posedge i_clk) begin
        cyc <= cyc + 1;
        if (cyc > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding", cyc,
                     decoded_due.size());
            $display("simulation failed");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input longint got, input longint want);
        errors++;
        $display("mismatch at cycle %0d: %s got %0d expected %0d", cyc, what, got, want);
    endtask

    // floor square root, argument below 2^32
    function automatic longint root_floor(input longint x);
        longint r;
        longint t;
        r = 0;
        for (int b = 16; b >= 0; b--) begin
            t = r | (longint'(1) << b);
            if (t * t <= x) r = t;
        end
        return r;
    endfunction

    function automatic logic [10:0] round_volt(input longint acc, input int q);
        longint r;
        if (acc <= 0) return '0;
        r = (acc + (longint'(1) << (q - 1))) >>> q;
        return (r > utd_pkg::VOLT_MAX) ? 11'(utd_pkg::VOLT_MAX) : 11'(r);
    endfunction

    function automatic logic [10:0] volt_from_byte(input logic [7:0] v);
        longint acc;
        longint n;
        longint d;
        if (v < 8'd144) return '0;
        acc = 0;
        for (int i = 0; i < 7; i++) begin
            n = 1;
            d = 1;
            for (int j = 0; j < 7; j++) begin
                if (j != i) begin
                    n = n * (longint'(v) - utd_pkg::NODES9[j]);
                    d = d * (utd_pkg::NODES9[i] - utd_pkg::NODES9[j]);
                end
            end
            acc = acc + utd_pkg::VALS9[i] * n * 256 / d;
        end
        return round_volt(acc, 8);
    endfunction

    function automatic logic [10:0] volt_from_word(input logic [15:0] w);
        longint s;
        longint acc;
        longint d;
        longint diff;
        logic [127:0] prod;
        logic [127:0] quo;
        bit neg;
        s = root_floor(longint'(w) << 16);
        if (s < 75 * 256) return '0;
        if (s > 145 * 256) return 11'd1400;
        for (int i = 0; i < 7; i++)
            if ((s >>> 8) == utd_pkg::NODES10[i]) return 11'(utd_pkg::VALS10[i]);
        acc = 0;
        for (int i = 0; i < 7; i++) begin
            prod = 128'(utd_pkg::VALS10[i]);
            neg = 1'b0;
            d = 1;
            for (int j = 0; j < 7; j++) begin
                if (j != i) begin
                    d = d * (utd_pkg::NODES10[i] - utd_pkg::NODES10[j]);
                    diff = s - utd_pkg::NODES10[j] * 256;
                    if (diff < 0) begin
                        neg = !neg;
                        diff = -diff;
                    end
                    prod = prod * 128'(diff);
                end
            end
            if (d < 0) begin
                neg = !neg;
                d = -d;
            end
            quo = (prod >> 32) / 128'(d);
            acc = neg ? acc - longint'(quo) : acc + longint'(quo);
        end
        return round_volt(acc, 16);
    endfunction

    function automatic logic signed [15:0] battery_level(input logic [7:0] raw);
        longint num;
        longint den;
        longint r;
        bit neg;
        num = (longint'(raw) - longint'(empty_raw)) * 1000;
        den = longint'(full_raw) - longint'(empty_raw);
        if (den == 0) return '0;
        neg = (num < 0) != (den < 0);
        if (num < 0) num = -num;
        if (den < 0) den = -den;
        r = (2 * num + den) / (2 * den);
        if (neg) r = -r;
        if (r > 32767) r = 32767;
        if (r < -32768) r = -32768;
        return 16'(r);
    endfunction

    // decode one packet and advance the running extremes
    function automatic utd_pkg::t_out_item decode_packet(input utd_pkg::t_in_item p);
        utd_pkg::t_out_item o;
        logic [10:0] v;
        v = p.ten_byte_format ? volt_from_word({p.volt_high, p.volt_low})
                              : volt_from_byte(p.volt_high);
        if (v >= peak_volt) peak_volt = v;
        if (v <= floor_volt) floor_volt = v;
        o.volt_tenths        = v;
        o.max_volt_tenths    = peak_volt;
        o.min_volt_tenths    = floor_volt;
        o.battery_tenths_pct = battery_level(p.batt_raw);
        o.freq_hundredths    = (p.period_count == 0) ? '0 :
            27'((longint'(utd_pkg::FREQ_SCALE) + p.period_count / 2) / p.period_count);
        o.period_zero        = (p.period_count == 0);
        o.boost              = (p.regulation_code == utd_pkg::REG_BOOST);
        o.trim               = (p.regulation_code == utd_pkg::REG_TRIM);
        o.on_line            = (p.line_code == utd_pkg::LINE_ONLINE);
        o.on_battery         = (p.line_code == utd_pkg::LINE_ON_BATT)
                               || (p.line_code == utd_pkg::LINE_LOW_BATT);
        o.low_battery        = (p.line_code == utd_pkg::LINE_LOW_BATT);
        return o;
    endfunction

    function automatic logic [10:0] volt_diff(input logic [10:0] a, input logic [10:0] b);
        return (a > b) ? a - b : b - a;
    endfunction

    // monitor: check result beats, then log accepted packets into the predictor
    always @(posedge i_clk) begin
        utd_pkg::t_out_item got;
        utd_pkg::t_out_item want;
        pkt_taken <= pkt_ch.valid && pkt_ch.ready;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            got = res_ch.payload;
            beats_out++;
            if (decoded_due.size() == 0) begin
                errors++;
                $display("result beat at cycle %0d with nothing expected", cyc);
            end else begin
                want = decoded_due.pop_front();
                // voltages carry a one-tenth tolerance
                if (volt_diff(got.volt_tenths, want.volt_tenths) > 1)
                    report_mismatch("volt_tenths", got.volt_tenths, want.volt_tenths);
                if (volt_diff(got.max_volt_tenths, want.max_volt_tenths) > 1)
                    report_mismatch("max_volt_tenths", got.max_volt_tenths,
                                    want.max_volt_tenths);
                if (volt_diff(got.min_volt_tenths, want.min_volt_tenths) > 1)
                    report_mismatch("min_volt_tenths", got.min_volt_tenths,
                                    want.min_volt_tenths);
                if (got.battery_tenths_pct !== want.battery_tenths_pct)
                    report_mismatch("battery_tenths_pct", got.battery_tenths_pct,
                                    want.battery_tenths_pct);
                if (got.freq_hundredths !== want.freq_hundredths)
                    report_mismatch("freq_hundredths", got.freq_hundredths,
                                    want.freq_hundredths);
                if (got.period_zero !== want.period_zero)
                    report_mismatch("period_zero", got.period_zero, want.period_zero);
                if (got.boost !== want.boost)
                    report_mismatch("boost", got.boost, want.boost);
                if (got.trim !== want.trim)
                    report_mismatch("trim", got.trim, want.trim);
                if (got.on_line !== want.on_line)
                    report_mismatch("on_line", got.on_line, want.on_line);
                if (got.on_battery !== want.on_battery)
                    report_mismatch("on_battery", got.on_battery, want.on_battery);
                if (got.low_battery !== want.low_battery)
                    report_mismatch("low_battery", got.low_battery, want.low_battery);
            end
        end
        if (i_rst_n && pkt_ch.valid && pkt_ch.ready) begin
            beats_in++;
            decoded_due.push_back(decode_packet(pkt_ch.payload));
        end
    end

    // driver: offer the next packet at the falling edge once the last was taken
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            pkt_ch.valid <= 1'b0;
        end else if (!pkt_ch.valid || pkt_taken) begin
            if (pending_pkts.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                pkt_ch.payload <= pending_pkts.pop_front();
                pkt_ch.valid   <= 1'b1;
            end else begin
                pkt_ch.valid <= 1'b0;
            end
        end
    end

    // receiver: random stalls, plus a long hold-off window to fill the block
    always @(negedge i_clk) begin
        if (cyc >= hold_from && cyc < hold_from + hold_len) begin
            res_ch.ready <= 1'b0;
        end else begin
            res_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic write_reg(input utd_pkg::t_cfg_idx idx, input logic [7:0] val);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        if (idx == utd_pkg::CFG_EMPTY) empty_raw = val;
        else full_raw = val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_thresholds(input logic [7:0] e, input logic [7:0] f);
        write_reg(utd_pkg::CFG_EMPTY, e);
        write_reg(utd_pkg::CFG_FULL, f);
    endtask

    // wait until every queued packet is taken and every result has come
    task automatic drain();
        while (pending_pkts.size() != 0 || pkt_ch.valid || decoded_due.size() != 0)
            @(posedge i_clk);
    endtask

    function automatic utd_pkg::t_in_item make_pkt(input bit ten, input logic [15:0] v,
                                                   input logic [7:0] b,
                                                   input logic [15:0] per,
                                                   input logic [7:0] rg,
                                                   input logic [7:0] ln);
        utd_pkg::t_in_item p;
        p.ten_byte_format = ten;
        p.volt_high       = v[15:8];
        p.volt_low        = v[7:0];
        p.batt_raw        = b;
        p.period_count    = per;
        p.regulation_code = rg;
        p.line_code       = ln;
        return p;
    endfunction

    function automatic logic [7:0] pick_code();
        case ($urandom_range(3))
            0: return utd_pkg::REG_NORMAL;
            1: return utd_pkg::REG_BOOST;
            2: return utd_pkg::REG_TRIM;
            default: return 8'($urandom);
        endcase
    endfunction

    // random packet, weighted toward the interesting voltage ranges
    function automatic utd_pkg::t_in_item random_pkt();
        utd_pkg::t_in_item p;
        int n;
        int sel;
        p = utd_pkg::t_in_item'({$urandom, $urandom});
        sel = $urandom_range(9);
        if (sel < 3) begin
            p.ten_byte_format = 1'b0;
            if (sel < 2) p.volt_high = 8'($urandom_range(255, 144));
        end else begin
            p.ten_byte_format = 1'b1;
            if (sel < 7) begin
                {p.volt_high, p.volt_low} = 16'($urandom_range(21100, 5600));
            end else if (sel == 7) begin
                // land near a curve node so the exact-value path is hit
                n = int'(utd_pkg::NODES10[$urandom_range(6)]);
                {p.volt_high, p.volt_low} = 16'(n * n + $urandom_range(2 * n));
            end
        end
        if ($urandom_range(15) == 0) p.period_count = '0;
        else if ($urandom_range(1)) p.period_count = 16'($urandom_range(22000, 15000));
        p.regulation_code = pick_code();
        p.line_code       = pick_code();
        return p;
    endfunction

    task automatic random_phase(input int count, input int idle, input int stall);
        send_idle_pct  = idle;
        recv_stall_pct = stall;
        for (int k = 0; k < count; k++) pending_pkts.push_back(random_pkt());
        drain();
    endtask

    initial begin
        cyc            = 0;
        errors         = 0;
        beats_in       = 0;
        beats_out      = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_from      = -1;
        hold_len       = 0;
        pkt_taken      = 1'b0;
        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_idx      = utd_pkg::CFG_EMPTY;
        i_cfg_data     = '0;
        pkt_ch.valid   = 1'b0;
        pkt_ch.payload = '0;
        res_ch.ready   = 1'b0;
        empty_raw      = utd_pkg::EMPTY_RESET;
        full_raw       = utd_pkg::FULL_RESET;
        peak_volt      = '0;
        floor_volt     = 11'h7FF;
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed packets under the reset thresholds
        pending_pkts.push_back(make_pkt(0, 16'h9000, 8'd168, 16'd20000,
                                        utd_pkg::REG_NORMAL, utd_pkg::LINE_ONLINE));
        pending_pkts.push_back(make_pkt(0, 16'h8F00, 8'd215, 16'd0,
                                        utd_pkg::REG_BOOST, utd_pkg::LINE_ON_BATT));
        pending_pkts.push_back(make_pkt(0, 16'h0000, 8'd0, 16'd1,
                                        utd_pkg::REG_TRIM, utd_pkg::LINE_LOW_BATT));
        pending_pkts.push_back(make_pkt(0, 16'hFFFF, 8'd255, 16'hFFFF, 8'd0, 8'd255));
        pending_pkts.push_back(make_pkt(0, 16'hC300, 8'd191, 16'd16667, 8'd51, 8'd51));
        pending_pkts.push_back(make_pkt(1, 16'd0, 8'd169, 16'd2,
                                        utd_pkg::REG_NORMAL, utd_pkg::LINE_ONLINE));
        pending_pkts.push_back(make_pkt(1, 16'hFFFF, 8'd214, 16'd3,
                                        utd_pkg::REG_BOOST, utd_pkg::LINE_ON_BATT));
        pending_pkts.push_back(make_pkt(1, 16'd5624, 8'd100, 16'd20000,
                                        utd_pkg::REG_TRIM, utd_pkg::LINE_LOW_BATT));
        pending_pkts.push_back(make_pkt(1, 16'd5625, 8'd200, 16'd16000,
                                        utd_pkg::REG_NORMAL, 8'd0));
        pending_pkts.push_back(make_pkt(1, 16'd21025, 8'd180, 16'd17000,
                                        utd_pkg::REG_BOOST, utd_pkg::LINE_ONLINE));
        pending_pkts.push_back(make_pkt(1, 16'd21026, 8'd170, 16'd18000,
                                        utd_pkg::REG_TRIM, utd_pkg::LINE_ON_BATT));
        pending_pkts.push_back(make_pkt(1, 16'd9604, 8'd190, 16'd19000,
                                        utd_pkg::REG_NORMAL, utd_pkg::LINE_ONLINE));
        pending_pkts.push_back(make_pkt(1, 16'd7000, 8'd195, 16'd20001,
                                        utd_pkg::REG_BOOST, utd_pkg::LINE_ONLINE));
        pending_pkts.push_back(make_pkt(1, 16'd13000, 8'd205, 16'd15000,
                                        utd_pkg::REG_TRIM, utd_pkg::LINE_ONLINE));
        pending_pkts.push_back(make_pkt(1, 16'h5555, 8'hAA, 16'h5555, 8'h55, 8'hAA));
        pending_pkts.push_back(make_pkt(0, 16'hAAAA, 8'h55, 16'hAAAA, 8'hAA, 8'h55));
        drain();

        // long receiver hold-off while the sender keeps offering
        hold_from = cyc + 20;
        hold_len  = 6000;
        random_phase(40, 0, 0);
        hold_len  = 0;

        random_phase(300, 0, 0);

        set_thresholds(8'd0, 8'd255);
        pending_pkts.push_back(make_pkt(0, 16'hF000, 8'd0, 16'd20000,
                                        utd_pkg::REG_NORMAL, utd_pkg::LINE_ONLINE));
        pending_pkts.push_back(make_pkt(0, 16'hF000, 8'd255, 16'd20000,
                                        utd_pkg::REG_NORMAL, utd_pkg::LINE_ONLINE));
        random_phase(300, 82, 0);

        // reversed thresholds give a negative slope
        set_thresholds(8'd255, 8'd0);
        random_phase(300, 0, 82);

        // equal thresholds give zero percent
        set_thresholds(8'd100, 8'd100);
        random_phase(250, 38, 38);

        // one-step span saturates hard
        set_thresholds(8'd0, 8'd1);
        random_phase(250, 0, 0);

        set_thresholds(8'($urandom), 8'($urandom));
        random_phase(250, 82, 82);

        set_thresholds(utd_pkg::EMPTY_RESET, utd_pkg::FULL_RESET);
        random_phase(150, 38, 38);

        repeat (DRAIN_WAIT) @(posedge i_clk);
        $display("covered %0d packets in and %0d results out, both packet forms,", beats_in,
                 beats_out);
        $display("seven threshold settings and idle, stall and hold-off patterns");
        if (errors == 0 && decoded_due.size() == 0 && beats_in == beats_out) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
